### design/dif_pkg.sv
package dif_pkg;

  typedef enum logic [1:0] {
    KIND_SET_MEAS = 2'd0,
    KIND_FUSE     = 2'd1,
    KIND_EMIT     = 2'd2,
    KIND_PRIOR    = 2'd3
  } kind_e;

  typedef enum logic [0:0] {
    CFG_NOISE_RECIP  = 1'b0,
    CFG_TRACK_WEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_READ = 10'b0000000010,
    S_C1   = 10'b0000000100,
    S_C2   = 10'b0000001000,
    S_C3   = 10'b0000010000,
    S_C4   = 10'b0000100000,
    S_C5   = 10'b0001000000,
    S_DIV  = 10'b0010000000,
    S_SQRT = 10'b0100000000,
    S_WB   = 10'b1000000000
  } state_e;

  localparam logic [31:0] SAT_U32 = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_S32 = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_S32 = 32'h8000_0000;

endpackage

### design/dif_ram.sv
module dif_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/dif_div.sv
module dif_div #(
  parameter int NW = 73,
  parameter int DW = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          ge;

  assign rem_sh  = {rem_q, quo_q[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      // one quotient bit a cycle, restoring
      rem_d = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_d = {quo_q[NW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### design/dif_isqrt.sv
module dif_isqrt #(
  parameter int RW = 48
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RW-1:0]     rad_i,
  output logic              done_o,
  output logic [RW/2-1:0]   root_o
);

  localparam int HW   = RW / 2;
  localparam int REMW = HW + 3;
  localparam int CW   = $clog2(HW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [RW-1:0]   rad_q, rad_d;
  logic [HW-1:0]   res_q, res_d;
  logic [REMW-1:0] rem_q, rem_d;
  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            ge;

  assign rem_sh = {rem_q[REMW-3:0], rad_q[RW-1:RW-2]};
  assign trial  = REMW'({res_q, 2'b01});
  assign ge     = rem_sh >= trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    res_d  = res_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(HW);
      rad_d  = rad_i;
      res_d  = '0;
      rem_d  = '0;
    end else if (busy_q) begin
      // two radicand bits in, one root bit out
      rad_d = {rad_q[RW-3:0], 2'b00};
      rem_d = ge ? rem_sh - trial : rem_sh;
      res_d = {res_q[HW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d;
    res_q <= res_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign root_o = res_q;

endmodule

### design/diagonal_information_fusion.sv
// Channel  Direction  Handshake                 Word
// in       sink       in_valid_i / in_stall_o   kind, entry index, operand
// out      source     out_valid_o / out_stall_i index, estimate, information, terms, flag
// cfg      sink       cfg_we_i                  register index, data
//
// One item at a time. A fuse takes one divider pass plus the root, or the root alone
// with zero total information; loading a prior takes two divider passes; a zero prior
// or a negative solver diagonal goes straight to write-back. Reset clears control
// state and valid bits; an entry never written reads as zero. The input stalls from
// acceptance until the result enters the output register, which holds while
// out_stall_i is high.
module diagonal_information_fusion #(
  parameter int NUM_PARAMS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         in_kind_i,
  input  logic [3:0]         in_entry_index_i,
  input  logic signed [31:0] in_operand_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         out_result_index_o,
  output logic signed [31:0] out_estimate_o,
  output logic [31:0]        out_information_o,
  output logic [31:0]        out_lhs_term_o,
  output logic signed [31:0] out_rhs_term_o,
  output logic               out_saturated_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i
);

  localparam int AW     = NUM_PARAMS > 1 ? $clog2(NUM_PARAMS) : 1;
  localparam int DIV_NW = (3 * FRAC_BITS + 1 > 66) ? 3 * FRAC_BITS + 1 : 66;
  localparam int DIV_DW = 64;
  localparam int SQ_RW  = 32 + FRAC_BITS + (FRAC_BITS % 2);
  localparam int SQ_HW  = SQ_RW / 2;

  dif_pkg::state_e state_q, state_d;
  dif_pkg::kind_e  kind_q, kind_d;
  logic [3:0]  idx_q, idx_d;
  logic [31:0] opd_q, opd_d;
  logic [31:0] est_q, est_d, he_q, he_d, hm_q, hm_d, root_q, root_d;
  logic        sat_q, sat_d, neg_q, neg_d, pass_q, pass_d;
  logic [31:0] lhs_q, lhs_d, rhs_q, rhs_d;
  logic [32:0] sum_q, sum_d, dm_q, dm_d;
  logic [31:0] heh_q, heh_d, hmh_q, hmh_d;
  logic [64:0] prod0_q, prod0_d, prod1_q, prod1_d;
  logic [63:0] bsq_q, bsq_d, wr_q, wr_d;
  logic [31:0] nr_q, tw_q;
  logic [NUM_PARAMS-1:0] vld_q;

  logic        out_valid_q, out_valid_d;
  logic [3:0]  out_idx_q;
  logic [31:0] out_est_q, out_info_q, out_lhs_q, out_rhs_q;
  logic        out_sat_q;
  logic        out_load;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr_w, ram_addr_r;
  logic [127:0]  ram_rdata, ram_word;
  logic          idx_ok;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [63:0]       div_den;
  logic              sq_start, sq_done;
  logic [SQ_RW-1:0]  sq_rad;
  logic [SQ_HW-1:0]  sq_root;

  // datapath terms
  logic [31:0]        bmag;
  logic [63:0]        mul_bsq, mul_wh, mul_wr;
  logic [62:0]        mul_vn;
  logic [32:0]        sumw;
  logic [31:0]        hehw, hmhw;
  logic signed [64:0] fmul0, fmul1;
  logic [65:0]        numsum, nummag;
  logic [32:0]        hsum;
  logic [31:0]        nh;
  logic [64:0]        vn_sh, wh_sh;
  logic [63:0]        wr_sh;
  logic signed [32:0] dsub;
  logic [64:0]        mul_lo, mul_hi;
  logic [96:0]        ptot;
  logic [63:0]        mshift;
  logic               ovf;

  assign idx_ok     = {3'b000, idx_q} < 7'(NUM_PARAMS);
  assign ram_addr_r = AW'(in_entry_index_i);
  assign ram_addr_w = AW'(idx_q);
  assign ram_word   = vld_q[ram_addr_w] ? ram_rdata : '0;

  assign bmag    = opd_q[31] ? 32'(-opd_q) : opd_q;
  assign mul_bsq = bmag * bmag;
  assign mul_vn  = opd_q[30:0] * nr_q;
  assign vn_sh   = {2'b00, mul_vn} >> FRAC_BITS;
  assign mul_wh  = tw_q * he_q;
  assign mul_wr  = tw_q * root_q;
  assign wh_sh   = prod0_q >> FRAC_BITS;
  assign wr_sh   = prod1_q[63:0] >> FRAC_BITS;

  assign sumw   = {1'b0, he_q} + {1'b0, hm_q};
  assign hehw   = sumw[32] ? (he_q >> 1) : he_q;
  assign hmhw   = sumw[32] ? (hm_q >> 1) : hm_q;
  assign fmul0  = $signed({1'b0, hehw}) * $signed(est_q);
  assign fmul1  = $signed({1'b0, hmh_q}) * $signed(opd_q);
  assign numsum = {prod0_q[64], prod0_q} + {prod1_q[64], prod1_q};
  assign nummag = numsum[65] ? 66'(-numsum) : numsum;
  assign hsum   = {1'b0, heh_q} + {1'b0, hmh_q};
  assign nh     = sum_q[32] ? dif_pkg::SAT_U32 : sum_q[31:0];

  assign dsub   = $signed({est_q[31], est_q}) - $signed({opd_q[31], opd_q});
  assign mul_lo = wr_q[31:0] * dm_q;
  assign mul_hi = wr_q[63:32] * dm_q;
  assign ptot   = {32'b0, prod0_q} + {prod1_q, 32'b0};
  assign ovf    = |ptot[96:64];
  assign mshift = ptot[63:0] >> FRAC_BITS;

  assign out_load = (state_q == dif_pkg::S_WB) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    idx_d       = idx_q;
    opd_d       = opd_q;
    est_d       = est_q;
    he_d        = he_q;
    hm_d        = hm_q;
    root_d      = root_q;
    sat_d       = sat_q;
    neg_d       = neg_q;
    pass_d      = pass_q;
    lhs_d       = lhs_q;
    rhs_d       = rhs_q;
    sum_d       = sum_q;
    dm_d        = dm_q;
    heh_d       = heh_q;
    hmh_d       = hmh_q;
    prod0_d     = prod0_q;
    prod1_d     = prod1_q;
    bsq_d       = bsq_q;
    wr_d        = wr_q;
    out_valid_d = out_valid_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    sq_start    = 1'b0;
    sq_rad      = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      dif_pkg::S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = dif_pkg::kind_e'(in_kind_i);
          idx_d   = in_entry_index_i;
          opd_d   = in_operand_i;
          ram_re  = 1'b1;
          sat_d   = 1'b0;
          lhs_d   = '0;
          rhs_d   = '0;
          state_d = dif_pkg::S_READ;
        end
      end
      dif_pkg::S_READ: begin
        if (idx_ok) begin
          est_d   = ram_word[31:0];
          he_d    = ram_word[63:32];
          hm_d    = ram_word[95:64];
          root_d  = ram_word[127:96];
          state_d = dif_pkg::S_C1;
        end else begin
          est_d   = '0;
          he_d    = '0;
          state_d = dif_pkg::S_WB;
        end
      end
      dif_pkg::S_C1: begin
        case (kind_q)
          dif_pkg::KIND_PRIOR: begin
            est_d = '0;
            hm_d  = '0;
            if (bmag == '0) begin
              root_d  = dif_pkg::SAT_U32;
              he_d    = dif_pkg::SAT_U32;
              sat_d   = 1'b1;
              state_d = dif_pkg::S_WB;
            end else begin
              div_start = 1'b1;
              div_num   = DIV_NW'(1) << (2 * FRAC_BITS);
              div_den   = 64'(bmag);
              bsq_d     = mul_bsq;
              pass_d    = 1'b0;
              state_d   = dif_pkg::S_DIV;
            end
          end
          dif_pkg::KIND_SET_MEAS: begin
            if (opd_q[31]) begin
              hm_d    = '0;
              sat_d   = nr_q != '0;
              state_d = dif_pkg::S_WB;
            end else begin
              state_d = dif_pkg::S_C2;
            end
          end
          dif_pkg::KIND_FUSE: begin
            sum_d   = sumw;
            heh_d   = hehw;
            hmh_d   = hmhw;
            prod0_d = fmul0;
            state_d = dif_pkg::S_C2;
          end
          default: begin
            prod0_d = {1'b0, mul_wh};
            state_d = dif_pkg::S_C2;
          end
        endcase
      end
      dif_pkg::S_C2: begin
        case (kind_q)
          dif_pkg::KIND_SET_MEAS: begin
            if (|vn_sh[64:32]) begin
              hm_d  = dif_pkg::SAT_U32;
              sat_d = 1'b1;
            end else begin
              hm_d = vn_sh[31:0];
            end
            state_d = dif_pkg::S_WB;
          end
          dif_pkg::KIND_FUSE: begin
            prod1_d = fmul1;
            state_d = dif_pkg::S_C3;
          end
          default: begin
            if (|wh_sh[64:32]) begin
              lhs_d = dif_pkg::SAT_U32;
              sat_d = 1'b1;
            end else begin
              lhs_d = wh_sh[31:0];
            end
            prod1_d = {1'b0, mul_wr};
            state_d = dif_pkg::S_C3;
          end
        endcase
      end
      dif_pkg::S_C3: begin
        if (kind_q == dif_pkg::KIND_FUSE) begin
          neg_d = numsum[65];
          if (sum_q == '0) begin
            // no information at all: keep the estimate
            he_d     = '0;
            sq_start = 1'b1;
            state_d  = dif_pkg::S_SQRT;
          end else begin
            div_start = 1'b1;
            div_num   = DIV_NW'(nummag);
            div_den   = 64'(hsum);
            state_d   = dif_pkg::S_DIV;
          end
        end else begin
          neg_d   = dsub[32];
          dm_d    = dsub[32] ? 33'(-dsub) : 33'(dsub);
          wr_d    = wr_sh;
          state_d = dif_pkg::S_C4;
        end
      end
      dif_pkg::S_C4: begin
        prod0_d = mul_lo;
        state_d = dif_pkg::S_C5;
      end
      dif_pkg::S_C5: begin
        prod1_d = mul_hi;
        state_d = dif_pkg::S_SQRT;
      end
      dif_pkg::S_DIV: begin
        if (div_done) begin
          if (kind_q == dif_pkg::KIND_PRIOR) begin
            if (!pass_q) begin
              if (|div_quo[DIV_NW-1:32]) begin
                root_d = dif_pkg::SAT_U32;
                sat_d  = 1'b1;
              end else begin
                root_d = div_quo[31:0];
              end
              div_start = 1'b1;
              div_num   = DIV_NW'(1) << (3 * FRAC_BITS);
              div_den   = bsq_q;
              pass_d    = 1'b1;
            end else begin
              if (|div_quo[DIV_NW-1:32]) begin
                he_d  = dif_pkg::SAT_U32;
                sat_d = 1'b1;
              end else begin
                he_d = div_quo[31:0];
              end
              state_d = dif_pkg::S_WB;
            end
          end else begin
            est_d    = neg_q ? 32'(-div_quo[31:0]) : div_quo[31:0];
            he_d     = nh;
            sat_d    = sat_q | sum_q[32];
            sq_start = 1'b1;
            sq_rad   = SQ_RW'({nh, {FRAC_BITS{1'b0}}});
            state_d  = dif_pkg::S_SQRT;
          end
        end
      end
      dif_pkg::S_SQRT: begin
        if (kind_q == dif_pkg::KIND_EMIT) begin
          // combine the partial products of the residual term
          if (ovf) begin
            sat_d = 1'b1;
            rhs_d = neg_q ? dif_pkg::MIN_S32 : dif_pkg::MAX_S32;
          end else if (!neg_q && mshift > 64'(dif_pkg::MAX_S32)) begin
            sat_d = 1'b1;
            rhs_d = dif_pkg::MAX_S32;
          end else if (neg_q && mshift > 64'(dif_pkg::MIN_S32)) begin
            sat_d = 1'b1;
            rhs_d = dif_pkg::MIN_S32;
          end else begin
            rhs_d = neg_q ? 32'(-mshift[31:0]) : mshift[31:0];
          end
          state_d = dif_pkg::S_WB;
        end else if (sq_done) begin
          root_d  = 32'(sq_root);
          state_d = dif_pkg::S_WB;
        end
      end
      dif_pkg::S_WB: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          ram_we      = idx_ok && (kind_q != dif_pkg::KIND_EMIT);
          state_d     = dif_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dif_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dif_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      nr_q        <= 32'(1) << FRAC_BITS;
      tw_q        <= 32'(1) << FRAC_BITS;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (ram_we) begin
        vld_q[ram_addr_w] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          dif_pkg::CFG_NOISE_RECIP:  nr_q <= cfg_wdata_i;
          dif_pkg::CFG_TRACK_WEIGHT: tw_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    idx_q   <= idx_d;
    opd_q   <= opd_d;
    est_q   <= est_d;
    he_q    <= he_d;
    hm_q    <= hm_d;
    root_q  <= root_d;
    sat_q   <= sat_d;
    neg_q   <= neg_d;
    pass_q  <= pass_d;
    lhs_q   <= lhs_d;
    rhs_q   <= rhs_d;
    sum_q   <= sum_d;
    dm_q    <= dm_d;
    heh_q   <= heh_d;
    hmh_q   <= hmh_d;
    prod0_q <= prod0_d;
    prod1_q <= prod1_d;
    bsq_q   <= bsq_d;
    wr_q    <= wr_d;
    if (out_load) begin
      out_idx_q  <= idx_q;
      out_est_q  <= est_q;
      out_info_q <= he_q;
      out_lhs_q  <= lhs_q;
      out_rhs_q  <= rhs_q;
      out_sat_q  <= sat_q;
    end
  end

  dif_ram #(
    .WIDTH (128),
    .DEPTH (NUM_PARAMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr_w),
    .wdata_i ({root_q, hm_q, he_q, est_q}),
    .re_i    (ram_re),
    .raddr_i (ram_addr_r),
    .rdata_o (ram_rdata)
  );

  dif_div #(
    .NW (DIV_NW),
    .DW (DIV_DW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  dif_isqrt #(
    .RW (SQ_RW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  assign in_stall_o         = state_q != dif_pkg::S_IDLE;
  assign out_valid_o        = out_valid_q;
  assign out_result_index_o = out_idx_q;
  assign out_estimate_o     = out_est_q;
  assign out_information_o  = out_info_q;
  assign out_lhs_term_o     = out_lhs_q;
  assign out_rhs_term_o     = out_rhs_q;
  assign out_saturated_o    = out_sat_q;

  a_rose_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == dif_pkg::S_WB))
    else $error("result word appeared outside write-back");

  a_write_in_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == dif_pkg::S_WB) && (kind_q != dif_pkg::KIND_EMIT))
    else $error("table written outside write-back or on emit");

  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == dif_pkg::S_READ))
    else $error("accepted word did not start a table read");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (state_q == dif_pkg::S_C1 || state_q == dif_pkg::S_C3 ||
                   state_q == dif_pkg::S_DIV))
    else $error("divider started from an unexpected step");

endmodule

### sim/diagonal_information_fusion_test.sv
module diagonal_information_fusion_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    dif_pkg::kind_e kind;
    logic [3:0]     idx;
    logic [31:0]    operand;
  } word_t;

  typedef struct {
    logic [3:0]  idx;
    logic [31:0] est;
    logic [31:0] info;
    logic [31:0] lhs;
    logic [31:0] rhs;
    logic        sat;
  } fused_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         in_kind_i = '0;
  logic [3:0]         in_entry_index_i = '0;
  logic signed [31:0] in_operand_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [3:0]         out_result_index_o;
  logic signed [31:0] out_estimate_o;
  logic [31:0]        out_information_o;
  logic [31:0]        out_lhs_term_o;
  logic signed [31:0] out_rhs_term_o;
  logic               out_saturated_o;
  logic               cfg_we_i = 1'b0;
  dif_pkg::cfg_idx_e  cfg_index_i = dif_pkg::CFG_NOISE_RECIP;
  logic [31:0]        cfg_wdata_i = '0;

  diagonal_information_fusion DUT (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [31:0] noise_recip;
  logic [31:0] track_wt;
  logic [31:0] est_tab [16];
  logic [31:0] info_tab [16];
  logic [31:0] root_tab [16];
  logic [31:0] meas_tab [16];

  word_t  pending_words[$];
  fused_t expected_fused[$];
  int     errors = 0;
  bit     quiet = 1'b0;
  bit     in_taken = 1'b0;
  int     in_gap = 0;
  int     stall_left = 0;

  function automatic logic [31:0] clip32(logic [63:0] x, inout logic sat);
    if (x > 64'hFFFF_FFFF) begin
      sat = 1'b1;
      return dif_pkg::SAT_U32;
    end
    return x[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'h1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic fused_t fuse_step(word_t w);
    fused_t      f;
    longint      v, mu, num, den, q, d, res;
    logic [63:0] b, qq, r, t, he, hm, sum, wr, dm, m, p;
    logic [127:0] prod;
    logic [31:0] nh;
    logic        sat;
    int          e;
    e = w.idx;
    v = longint'($signed(w.operand));
    sat = 1'b0;
    f.lhs = '0;
    f.rhs = '0;
    case (w.kind)
      dif_pkg::KIND_PRIOR: begin
        b = (v < 0) ? -v : v;
        est_tab[e] = '0;
        meas_tab[e] = '0;
        if (b == 0) begin
          root_tab[e] = dif_pkg::SAT_U32;
          info_tab[e] = dif_pkg::SAT_U32;
          sat = 1'b1;
        end else begin
          qq = 64'h1_0000_0000 / b;
          r = 64'h1_0000_0000 % b;
          root_tab[e] = clip32(qq, sat);
          if (b * b <= 64'h1_0000) begin
            info_tab[e] = dif_pkg::SAT_U32;
            sat = 1'b1;
          end else begin
            t = (qq << 16) + ((r << 16) / b);
            info_tab[e] = clip32(t / b, sat);
          end
        end
      end
      dif_pkg::KIND_SET_MEAS: begin
        if (v < 0) begin
          meas_tab[e] = '0;
          if (noise_recip != 0) sat = 1'b1;
        end else begin
          p = ({32'b0, w.operand} * {32'b0, noise_recip}) >> 16;
          meas_tab[e] = clip32(p, sat);
        end
      end
      dif_pkg::KIND_FUSE: begin
        he = {32'b0, info_tab[e]};
        hm = {32'b0, meas_tab[e]};
        sum = he + hm;
        if (sum != 0) begin
          // halve both weights when the total overflows 32 bits
          if (sum > 64'hFFFF_FFFF) begin
            he = he >> 1;
            hm = hm >> 1;
          end
          mu = longint'($signed(est_tab[e]));
          num = $signed(he) * mu + $signed(hm) * v;
          den = $signed(he + hm);
          q = num / den;
          est_tab[e] = q[31:0];
        end
        nh = clip32(sum, sat);
        info_tab[e] = nh;
        root_tab[e] = 32'(int_sqrt({16'b0, nh, 16'b0}));
      end
      default: begin
        f.lhs = clip32(({32'b0, track_wt} * {32'b0, info_tab[e]}) >> 16, sat);
        wr = ({32'b0, track_wt} * {32'b0, root_tab[e]}) >> 16;
        d = longint'($signed(est_tab[e])) - v;
        dm = (d < 0) ? -d : d;
        prod = {64'b0, wr} * {64'b0, dm};
        if (prod[127:64] != 0) begin
          sat = 1'b1;
          res = (d < 0) ? -64'sh8000_0000 : 64'sh7FFF_FFFF;
        end else begin
          m = prod[63:0] >> 16;
          if (d >= 0 && m > 64'h7FFF_FFFF) begin
            sat = 1'b1;
            res = 64'sh7FFF_FFFF;
          end else if (d < 0 && m > 64'h8000_0000) begin
            sat = 1'b1;
            res = -64'sh8000_0000;
          end else begin
            res = (d < 0) ? -$signed(m) : $signed(m);
          end
        end
        f.rhs = res[31:0];
      end
    endcase
    f.idx = w.idx;
    f.est = est_tab[e];
    f.info = info_tab[e];
    f.sat = sat;
    return f;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  // input driver
  always @(negedge clk_i) begin
    word_t w;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (pending_words.size() > 0) begin
        w = pending_words.pop_front();
        in_kind_i <= w.kind;
        in_entry_index_i <= w.idx;
        in_operand_i <= w.operand;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  // output stall bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 18);
    end
  end

  // accept, predict and check
  always @(posedge clk_i) begin
    word_t  w;
    fused_t f;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      w.kind = dif_pkg::kind_e'(in_kind_i);
      w.idx = in_entry_index_i;
      w.operand = in_operand_i;
      expected_fused.push_back(fuse_step(w));
      in_taken = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 18);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_fused.size() == 0) begin
        report("unexpected word", {28'b0, out_result_index_o}, '0);
      end else begin
        f = expected_fused.pop_front();
        if (out_result_index_o != f.idx)
          report("index", 32'(out_result_index_o), 32'(f.idx));
        if (out_estimate_o != f.est) report("estimate", out_estimate_o, f.est);
        if (out_information_o != f.info) report("information", out_information_o, f.info);
        if (out_lhs_term_o != f.lhs) report("lhs_term", out_lhs_term_o, f.lhs);
        if (out_rhs_term_o != f.rhs) report("rhs_term", out_rhs_term_o, f.rhs);
        if (out_saturated_o != f.sat)
          report("saturated", 32'(out_saturated_o), 32'(f.sat));
      end
    end
  end

  task automatic send(dif_pkg::kind_e k, int e, logic [31:0] op);
    word_t w;
    w.kind = k;
    w.idx = e[3:0];
    w.operand = op;
    pending_words.push_back(w);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_fused.size() != 0)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_cfg(dif_pkg::cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    if (idx == dif_pkg::CFG_NOISE_RECIP) noise_recip = data;
    else track_wt = data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return $urandom_range(32'h0000_0100, 32'h0100_0000);
      default: return $urandom_range(0, 32'h7FFF_FFFF);
    endcase
  endfunction

  task automatic random_words(int n);
    int cnt, e, r;
    cnt = 0;
    while (cnt < n) begin
      e = $urandom_range(0, 15);
      if ($urandom_range(0, 4) == 0) begin
        send(dif_pkg::kind_e'($urandom_range(0, 3)), e, pick_operand());
        cnt++;
      end else begin
        send(dif_pkg::KIND_PRIOR, e, pick_operand());
        r = $urandom_range(1, 3);
        repeat (r) begin
          send(dif_pkg::KIND_SET_MEAS, e, pick_operand());
          send(dif_pkg::KIND_FUSE, e, pick_operand());
        end
        send(dif_pkg::KIND_EMIT, e, pick_operand());
        cnt += 2 * r + 2;
      end
    end
  endtask

  initial begin
    noise_recip = 32'h0001_0000;
    track_wt = 32'h0001_0000;
    for (int i = 0; i < 16; i++) begin
      est_tab[i] = '0;
      info_tab[i] = '0;
      root_tab[i] = '0;
      meas_tab[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // fuse and emit on an entry never loaded: zero total information
    send(dif_pkg::KIND_FUSE, 0, 32'h0001_0000);
    send(dif_pkg::KIND_EMIT, 0, 32'h8000_0000);
    send(dif_pkg::KIND_PRIOR, 1, 32'h0000_0000);
    send(dif_pkg::KIND_PRIOR, 2, 32'h0000_0100);
    send(dif_pkg::KIND_PRIOR, 3, 32'h0000_0101);
    send(dif_pkg::KIND_PRIOR, 4, 32'h7FFF_FFFF);
    send(dif_pkg::KIND_PRIOR, 5, 32'h8000_0000);
    send(dif_pkg::KIND_PRIOR, 6, 32'hFFFF_0000);
    send(dif_pkg::KIND_SET_MEAS, 6, 32'hFFFF_FFFF);
    send(dif_pkg::KIND_SET_MEAS, 6, 32'h7FFF_FFFF);
    send(dif_pkg::KIND_FUSE, 6, 32'h7FFF_FFFF);
    // saturated prior plus large measured information: total overflows
    send(dif_pkg::KIND_SET_MEAS, 1, 32'h7FFF_FFFF);
    send(dif_pkg::KIND_FUSE, 1, 32'h8000_0000);
    send(dif_pkg::KIND_EMIT, 1, 32'h7FFF_FFFF);
    send(dif_pkg::KIND_EMIT, 1, 32'h8000_0000);
    send(dif_pkg::KIND_SET_MEAS, 15, 32'h0002_0000);
    send(dif_pkg::KIND_FUSE, 15, 32'hFFFE_0000);
    send(dif_pkg::KIND_EMIT, 15, 32'h0000_0000);
    send(dif_pkg::KIND_EMIT, 6, 32'h0000_0001);
    send(dif_pkg::KIND_FUSE, 4, 32'h0000_0000);
    drain();

    write_cfg(dif_pkg::CFG_NOISE_RECIP, 32'h0000_0000);
    write_cfg(dif_pkg::CFG_TRACK_WEIGHT, 32'h0000_0000);
    random_words(120);
    drain();

    write_cfg(dif_pkg::CFG_NOISE_RECIP, 32'hFFFF_FFFF);
    write_cfg(dif_pkg::CFG_TRACK_WEIGHT, 32'hFFFF_FFFF);
    random_words(150);
    drain();

    write_cfg(dif_pkg::CFG_NOISE_RECIP, $urandom);
    write_cfg(dif_pkg::CFG_TRACK_WEIGHT, $urandom_range(0, 32'h0004_0000));
    random_words(200);
    drain();

    // last part runs without idling on either side
    quiet = 1'b1;
    write_cfg(dif_pkg::CFG_NOISE_RECIP, 32'h0001_0000);
    write_cfg(dif_pkg::CFG_TRACK_WEIGHT, 32'h0001_0000);
    random_words(160);
    drain();

    if (errors == 0) begin
      $display("diagonal_information_fusion_test OK");
    end else begin
      $display("diagonal_information_fusion_test NOT OK");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("diagonal_information_fusion_test NOT OK");
    $finish;
  end

endmodule

### files.f
design/dif_pkg.sv
design/dif_ram.sv
design/dif_div.sv
design/dif_isqrt.sv
design/diagonal_information_fusion.sv
sim/diagonal_information_fusion_test.sv
